@@ design/multi_pattern_string_matcher_unit_macros.svh @@
// Assertion macros for the multi-pattern string matcher.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MULTI_PATTERN_STRING_MATCHER_UNIT_MACROS_SVH
`define MULTI_PATTERN_STRING_MATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define MPSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mpsm_pkg.sv @@
// Shared types and constants for the multi-pattern string matcher.
// No dependencies.
`timescale 1ns / 1ps

package mpsm_pkg;

    localparam int ALPHABET_DEF  = 64;
    localparam int MAX_NODES_DEF = 1024;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_END     = 3'd1,
        OP_BUILD   = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_RESTART = 3'd4
    } op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_CHK,
        S_SR_CHK,
        S_SR_FAIL,
        S_SR_END,
        S_B_ROOT,
        S_B_ROOT_CHK,
        S_B_DEQ,
        S_B_DEQ_WAIT,
        S_B_NFAIL,
        S_B_CHILD,
        S_B_CHILD_CHK,
        S_B_WALK_CHK,
        S_B_FAIL_WAIT,
        S_B_END_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [5:0] symbol;
    } req_t;

    typedef struct packed {
        logic       status;
        logic       match_now;
        logic       found;
        logic [9:0] node;
    } res_t;

    typedef struct packed {
        logic ready;
        logic clearing;
    } core_stat_t;

endpackage

@@ design/mpsm_in_if.sv @@
// Input channel: opcode and symbol with valid/ready.
// No dependencies.
`timescale 1ns / 1ps

interface mpsm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [5:0] symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

@@ design/mpsm_out_if.sv @@
// Result channel: status, match, found flag and search node with valid/ready.
// No dependencies.
`timescale 1ns / 1ps

interface mpsm_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic       match_now;
    logic       found;
    logic [9:0] node;

    modport source (output valid, output status, output match_now, output found,
                    output node, input ready);
    modport sink   (input valid, input status, input match_now, input found,
                    input node, output ready);
endinterface

@@ design/mpsm_core.sv @@
// Sequencer, trie memories and BFS queue of the matcher.
// Depends on mpsm_pkg.
`timescale 1ns / 1ps

module mpsm_core
    import mpsm_pkg::*;
#(
    parameter int ALPHABET  = ALPHABET_DEF,
    parameter int MAX_NODES = MAX_NODES_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  req_t       cmd,
    input  logic       out_free,
    output core_stat_t stat,
    output logic       done,
    output res_t       res
);

    localparam int NW         = $clog2(MAX_NODES);
    localparam int SW         = $clog2(ALPHABET);
    localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
    localparam int AW         = $clog2(GOTO_DEPTH);

    function automatic logic [SW-1:0] sym_mod(input logic [5:0] x);
        int v;
        v = int'(x);
        for (int k = 5; k >= 0; k--)
        begin
            if (v >= (ALPHABET << k))
                v = v - (ALPHABET << k);
        end
        return SW'(v);
    endfunction

    function automatic logic [AW-1:0] gaddr(input logic [NW-1:0] nd,
                                            input logic [SW-1:0] sy);
        return AW'(nd) * AW'(ALPHABET) + AW'(sy);
    endfunction

    // memories
    logic [NW-1:0] goto_mem  [GOTO_DEPTH];
    logic [NW-1:0] fail_mem  [MAX_NODES];
    logic          end_mem   [MAX_NODES];
    logic [NW-1:0] queue_mem [MAX_NODES];

    logic [AW-1:0] goto_raddr, goto_waddr;
    logic [NW-1:0] goto_wdata, goto_rdata;
    logic          goto_we;
    logic [NW-1:0] fail_raddr, fail_waddr, fail_wdata, fail_rdata;
    logic          fail_we;
    logic [NW-1:0] end_raddr, end_waddr;
    logic          end_wdata, end_rdata, end_we;
    logic [NW-1:0] q_raddr, q_waddr, q_wdata, q_rdata;
    logic          q_we;

    always_ff @(posedge clk)
    begin
        if (goto_we)
            goto_mem[goto_waddr] <= goto_wdata;
        goto_rdata <= goto_mem[goto_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
            fail_mem[fail_waddr] <= fail_wdata;
        fail_rdata <= fail_mem[fail_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (end_we)
            end_mem[end_waddr] <= end_wdata;
        end_rdata <= end_mem[end_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            queue_mem[q_waddr] <= q_wdata;
        q_rdata <= queue_mem[q_raddr];
    end

    // sequencer registers
    state_t        state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [SW-1:0] sym_reg, sym_next;
    logic [NW-1:0] ins_reg, ins_next;
    logic          cut_reg, cut_next;
    logic [NW:0]   cnt_reg, cnt_next;
    logic [NW-1:0] srch_reg, srch_next;
    logic          found_reg, found_next;
    logic          status_reg, status_next;
    logic          match_reg, match_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] fn_reg, fn_next;
    logic [NW-1:0] f_reg, f_next;
    logic [NW-1:0] c_reg, c_next;
    logic [SW-1:0] s_reg, s_next;
    logic [NW:0]   head_reg, head_next;
    logic [NW:0]   tail_reg, tail_next;

    logic [SW-1:0] sym_in;
    logic          last_s;

    assign sym_in = sym_mod(cmd.symbol);
    assign last_s = (s_reg == SW'(ALPHABET - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            ins_reg    <= '0;
            cut_reg    <= 1'b0;
            cnt_reg    <= (NW+1)'(1);
            srch_reg   <= '0;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
            match_reg  <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            s_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ins_reg    <= ins_next;
            cut_reg    <= cut_next;
            cnt_reg    <= cnt_next;
            srch_reg   <= srch_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            match_reg  <= match_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            s_reg      <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        n_reg   <= n_next;
        fn_reg  <= fn_next;
        f_reg   <= f_next;
        c_reg   <= c_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        sym_next    = sym_reg;
        ins_next    = ins_reg;
        cut_next    = cut_reg;
        cnt_next    = cnt_reg;
        srch_next   = srch_reg;
        found_next  = found_reg;
        status_next = status_reg;
        match_next  = match_reg;
        n_next      = n_reg;
        fn_next     = fn_reg;
        f_next      = f_reg;
        c_next      = c_reg;
        s_next      = s_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;

        goto_raddr = '0;
        goto_we    = 1'b0;
        goto_waddr = clr_reg;
        goto_wdata = '0;
        fail_raddr = '0;
        fail_we    = 1'b0;
        fail_waddr = clr_reg[NW-1:0];
        fail_wdata = '0;
        end_raddr  = '0;
        end_we     = 1'b0;
        end_waddr  = clr_reg[NW-1:0];
        end_wdata  = 1'b0;
        q_raddr    = head_reg[NW-1:0];
        q_we       = 1'b0;
        q_waddr    = tail_reg[NW-1:0];
        q_wdata    = goto_rdata;
        done       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                goto_we  = 1'b1;
                fail_we  = 1'b1;
                end_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(GOTO_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    sym_next    = sym_in;
                    status_next = 1'b0;
                    match_next  = 1'b0;
                    state_next  = S_DONE;
                    case (op_t'(cmd.opcode))
                        OP_INSERT:
                        begin
                            if (cut_reg)
                                status_next = 1'b1;
                            else
                            begin
                                goto_raddr = gaddr(ins_reg, sym_in);
                                state_next = S_INS_CHK;
                            end
                        end
                        OP_END:
                        begin
                            if (!cut_reg)
                            begin
                                end_we    = 1'b1;
                                end_waddr = ins_reg;
                                end_wdata = 1'b1;
                            end
                            ins_next = '0;
                            cut_next = 1'b0;
                        end
                        OP_BUILD:
                        begin
                            s_next     = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = S_B_ROOT;
                        end
                        OP_SEARCH:
                        begin
                            n_next     = srch_reg;
                            goto_raddr = gaddr(srch_reg, sym_in);
                            state_next = S_SR_CHK;
                        end
                        OP_RESTART:
                        begin
                            srch_next  = '0;
                            found_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_CHK:
            begin
                if (goto_rdata != '0)
                    ins_next = goto_rdata;
                else if (cnt_reg >= (NW+1)'(MAX_NODES))
                begin
                    status_next = 1'b1;
                    cut_next    = 1'b1;
                end
                else
                begin
                    goto_we    = 1'b1;
                    goto_waddr = gaddr(ins_reg, sym_reg);
                    goto_wdata = cnt_reg[NW-1:0];
                    fail_we    = 1'b1;
                    fail_waddr = cnt_reg[NW-1:0];
                    end_we     = 1'b1;
                    end_waddr  = cnt_reg[NW-1:0];
                    ins_next   = cnt_reg[NW-1:0];
                    cnt_next   = cnt_reg + (NW+1)'(1);
                end
                state_next = S_DONE;
            end
            S_SR_CHK:
            begin
                if (goto_rdata != '0 || n_reg == '0)
                begin
                    srch_next  = goto_rdata;
                    end_raddr  = goto_rdata;
                    state_next = S_SR_END;
                end
                else
                begin
                    fail_raddr = n_reg;
                    state_next = S_SR_FAIL;
                end
            end
            S_SR_FAIL:
            begin
                n_next     = fail_rdata;
                goto_raddr = gaddr(fail_rdata, sym_reg);
                state_next = S_SR_CHK;
            end
            S_SR_END:
            begin
                match_next = end_rdata;
                if (end_rdata)
                    found_next = 1'b1;
                state_next = S_DONE;
            end
            S_B_ROOT:
            begin
                goto_raddr = gaddr('0, s_reg);
                state_next = S_B_ROOT_CHK;
            end
            S_B_ROOT_CHK:
            begin
                if (goto_rdata != '0)
                begin
                    fail_we    = 1'b1;
                    fail_waddr = goto_rdata;
                    if (tail_reg < (NW+1)'(MAX_NODES))
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + (NW+1)'(1);
                    end
                end
                s_next     = s_reg + SW'(1);
                state_next = last_s ? S_B_DEQ : S_B_ROOT;
            end
            S_B_DEQ:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + (NW+1)'(1);
                    state_next = S_B_DEQ_WAIT;
                end
                else
                    state_next = S_DONE;
            end
            S_B_DEQ_WAIT:
            begin
                n_next     = q_rdata;
                fail_raddr = q_rdata;
                state_next = S_B_NFAIL;
            end
            S_B_NFAIL:
            begin
                fn_next    = fail_rdata;
                s_next     = '0;
                state_next = S_B_CHILD;
            end
            S_B_CHILD:
            begin
                goto_raddr = gaddr(n_reg, s_reg);
                state_next = S_B_CHILD_CHK;
            end
            S_B_CHILD_CHK:
            begin
                if (goto_rdata == '0)
                begin
                    s_next     = s_reg + SW'(1);
                    state_next = last_s ? S_B_DEQ : S_B_CHILD;
                end
                else
                begin
                    c_next     = goto_rdata;
                    f_next     = fn_reg;
                    goto_raddr = gaddr(fn_reg, s_reg);
                    state_next = S_B_WALK_CHK;
                end
            end
            S_B_WALK_CHK:
            begin
                if (f_reg != '0 && goto_rdata == '0)
                begin
                    fail_raddr = f_reg;
                    state_next = S_B_FAIL_WAIT;
                end
                else
                begin
                    fail_we    = 1'b1;
                    fail_waddr = c_reg;
                    fail_wdata = goto_rdata;
                    end_raddr  = goto_rdata;
                    q_wdata    = c_reg;
                    if (tail_reg < (NW+1)'(MAX_NODES))
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + (NW+1)'(1);
                    end
                    state_next = S_B_END_WAIT;
                end
            end
            S_B_FAIL_WAIT:
            begin
                f_next     = fail_rdata;
                goto_raddr = gaddr(fail_rdata, s_reg);
                state_next = S_B_WALK_CHK;
            end
            S_B_END_WAIT:
            begin
                if (end_rdata)
                begin
                    end_we    = 1'b1;
                    end_waddr = c_reg;
                    end_wdata = 1'b1;
                end
                s_next     = s_reg + SW'(1);
                state_next = last_s ? S_B_DEQ : S_B_CHILD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign stat.ready     = (state_reg == S_IDLE);
    assign stat.clearing  = (state_reg == S_CLEAR);
    assign res.status     = status_reg;
    assign res.match_now  = match_reg;
    assign res.found      = found_reg;
    assign res.node       = 10'(srch_reg);

endmodule

@@ design/multi_pattern_string_matcher_unit.sv @@
// Top level of the Aho-Corasick multi-pattern matcher: channels and result register.
// Depends on mpsm_pkg, mpsm_in_if, mpsm_out_if, mpsm_core and the macro header.
`timescale 1ns / 1ps
`include "multi_pattern_string_matcher_unit_macros.svh"

// Aho-Corasick matcher driven by a single sequencer over one read port per memory.
// After reset the goto table is swept clear with ready low. An insert reads the
// goto entry of the current node and adds a node if none exists; a search reads
// the goto entry, follows failure links while it is empty at a non-root node,
// then reads the end flag of the node reached. A build links the root's children
// first, then takes each queued node in breadth-first order and walks failure
// links for each child to set its link and end flag. One item is worked on at a
// time; a finished result waits in the output register while the next item is taken.
module multi_pattern_string_matcher_unit
    import mpsm_pkg::*;
#(
    parameter int ALPHABET  = ALPHABET_DEF,
    parameter int MAX_NODES = MAX_NODES_DEF
)(
    input logic        clk,
    input logic        rst_n,
    mpsm_in_if.sink    req,
    mpsm_out_if.source rsp
);

    req_t       cmd;
    res_t       core_res;
    core_stat_t stat;
    logic       start, done, out_free;
    logic       out_valid_reg;
    res_t       out_res_reg;

    assign cmd.opcode = req.opcode;
    assign cmd.symbol = req.symbol;
    assign req.ready  = stat.ready;
    assign start      = req.valid && stat.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    mpsm_core #(
        .ALPHABET  (ALPHABET),
        .MAX_NODES (MAX_NODES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .out_free (out_free),
        .stat     (stat),
        .done     (done),
        .res      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_res_reg <= core_res;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_res_reg.status;
    assign rsp.match_now = out_res_reg.match_now;
    assign rsp.found     = out_res_reg.found;
    assign rsp.node      = out_res_reg.node;

    `MPSM_ASSERT_IMP(a_no_take_clear, stat.clearing, !req.ready, "item taken during clear")
    `MPSM_ASSERT_IMP(a_match_found, rsp.valid && rsp.match_now, rsp.found,
                     "match without found flag")
    `MPSM_ASSERT_IMP(a_done_room, done, out_free, "result overwrites pending transfer")
    `MPSM_ASSERT_NXT(a_done_valid, done, rsp.valid, "result register not loaded")

endmodule

@@ bench/tb.sv @@
// Self-checking bench for multi_pattern_string_matcher_unit: trie loads, link builds, searches.
// Depends on mpsm_pkg, mpsm_in_if and mpsm_out_if; results checked against a built-in trie model.
`timescale 1ns / 1ps

module tb;
    import mpsm_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;
    localparam int NODES = MAX_NODES_DEF;
    localparam int SYMS  = ALPHABET_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mpsm_in_if  in_if();
    mpsm_out_if out_if();

    multi_pattern_string_matcher_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_if),
        .rsp   (out_if)
    );

    always #5 clk = ~clk;

    // trie model
    logic [9:0] trie_next [0:NODES*SYMS-1];
    logic [9:0] fail_to [0:NODES-1];
    logic       ends_here [0:NODES-1];
    int         nodes_used;
    logic [9:0] ins_at;
    logic [9:0] cur_node;
    logic       seen_match;
    logic       pat_cut;

    res_t expected_rsp [$];
    bit   failed;
    bit   quiet;
    int   stall_left;
    int   sent;

    function automatic logic [9:0] child(logic [9:0] n, logic [5:0] s);
        return trie_next[int'(n) * SYMS + int'(s)];
    endfunction

    task automatic clear_trie_model();
        for (int i = 0; i < NODES * SYMS; i++)
            trie_next[i] = '0;
        for (int i = 0; i < NODES; i++)
        begin
            fail_to[i] = '0;
            ends_here[i] = 1'b0;
        end
        nodes_used = 1;
        ins_at = '0;
        cur_node = '0;
        seen_match = 1'b0;
        pat_cut = 1'b0;
    endtask

    task automatic build_fail_links();
        logic [9:0] order [$];
        logic [9:0] n, c, f, t;
        int guard;
        for (int s = 0; s < SYMS; s++)
        begin
            c = child('0, 6'(s));
            if (c != 0)
            begin
                fail_to[c] = '0;
                order.push_back(c);
            end
        end
        while (order.size() > 0)
        begin
            n = order.pop_front();
            for (int s = 0; s < SYMS; s++)
            begin
                c = child(n, 6'(s));
                if (c == 0)
                    continue;
                f = fail_to[n];
                guard = 0;
                while (f != 0 && child(f, 6'(s)) == 0 && guard < NODES)
                begin
                    f = fail_to[f];
                    guard++;
                end
                t = child(f, 6'(s));
                fail_to[c] = t;
                ends_here[c] = ends_here[c] | ends_here[t];
                order.push_back(c);
            end
        end
    endtask

    task automatic advance_trie_model(logic [2:0] op, logic [5:0] sym);
        res_t r;
        logic [9:0] n, c;
        int guard;
        r = '0;
        case (op)
            OP_INSERT:
            begin
                if (pat_cut)
                    r.status = 1'b1;
                else
                begin
                    c = child(ins_at, sym);
                    if (c == 0)
                    begin
                        if (nodes_used >= NODES)
                        begin
                            r.status = 1'b1;
                            pat_cut = 1'b1;
                        end
                        else
                        begin
                            c = 10'(nodes_used);
                            nodes_used++;
                            trie_next[int'(ins_at) * SYMS + int'(sym)] = c;
                            fail_to[c] = '0;
                            ends_here[c] = 1'b0;
                        end
                    end
                    if (!pat_cut)
                        ins_at = c;
                end
            end
            OP_END:
            begin
                if (!pat_cut)
                    ends_here[ins_at] = 1'b1;
                ins_at = '0;
                pat_cut = 1'b0;
            end
            OP_BUILD:
                build_fail_links();
            OP_SEARCH:
            begin
                n = cur_node;
                guard = 0;
                while (n != 0 && child(n, sym) == 0 && guard < NODES)
                begin
                    n = fail_to[n];
                    guard++;
                end
                n = child(n, sym);
                cur_node = n;
                r.match_now = ends_here[n];
                if (ends_here[n])
                    seen_match = 1'b1;
            end
            OP_RESTART:
            begin
                cur_node = '0;
                seen_match = 1'b0;
            end
            default:
                ;
        endcase
        r.found = seen_match;
        r.node = cur_node;
        expected_rsp.push_back(r);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send(logic [2:0] op, logic [5:0] sym);
        int gap;
        in_if.valid <= 1'b1;
        in_if.opcode <= op;
        in_if.symbol <= sym;
        do
            @(posedge clk);
        while (!in_if.ready);
        advance_trie_model(op, sym);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp.size() > 0);
    endtask

    function automatic logic [5:0] text_sym();
        return ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(3));
    endfunction

    // result checker and sink stalls
    always @(posedge clk)
    begin
        res_t e;
        if (out_if.valid && out_if.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected transfer: node %0d", out_if.node);
                failed = 1'b1;
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (out_if.status !== e.status)
                begin
                    $error("status exp %0d act %0d", e.status, out_if.status);
                    failed = 1'b1;
                end
                if (out_if.match_now !== e.match_now)
                begin
                    $error("match_now exp %0d act %0d", e.match_now, out_if.match_now);
                    failed = 1'b1;
                end
                if (out_if.found !== e.found)
                begin
                    $error("found exp %0d act %0d", e.found, out_if.found);
                    failed = 1'b1;
                end
                if (out_if.node !== e.node)
                begin
                    $error("node exp %0d act %0d", e.node, out_if.node);
                    failed = 1'b1;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end
        else
        begin
            out_if.ready <= 1'b1;
            if (!quiet && $urandom_range(9) == 0)
                stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                       : $urandom_range(3, 1);
        end
    end

    task automatic test_directed();
        send(OP_INSERT, 6'd63);
        send(OP_INSERT, 6'd0);
        send(OP_END, 6'd0);
        send(OP_INSERT, 6'd0);
        send(OP_END, 6'd0);
        send(OP_SPARE_A, 6'd21);
        send(OP_SPARE_B, 6'd42);
        send(OP_SPARE_C, 6'd63);
        send(OP_SEARCH, 6'd63);
        send(OP_SEARCH, 6'd0);
        send(OP_BUILD, 6'd0);
        send(OP_SEARCH, 6'd63);
        send(OP_SEARCH, 6'd0);
        send(OP_SEARCH, 6'd0);
        send(OP_SEARCH, 6'd5);
        send(OP_RESTART, 6'd0);
        // inserted after the build, links stay at root
        send(OP_INSERT, 6'd63);
        send(OP_INSERT, 6'd1);
        send(OP_END, 6'd0);
        send(OP_SEARCH, 6'd63);
        send(OP_SEARCH, 6'd1);
        send(OP_SEARCH, 6'd63);
        send(OP_RESTART, 6'd63);
    endtask

    task automatic test_random();
        int roll, len, builds;
        builds = 0;
        while (sent < 150)
        begin
            if (sent % 100 < 10)
                quiet = 1'b1;
            else
                quiet = 1'b0;
            roll = $urandom_range(99);
            if (roll < 35 && nodes_used < 300)
            begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++)
                    send(OP_INSERT, text_sym());
                if ($urandom_range(9) != 0)
                    send(OP_END, 6'($urandom_range(63)));
            end
            else if (roll < 40 && builds < 8)
            begin
                builds++;
                send(OP_BUILD, 6'($urandom_range(63)));
            end
            else if (roll < 85)
            begin
                len = $urandom_range(12, 1);
                for (int i = 0; i < len; i++)
                    send(OP_SEARCH, text_sym());
            end
            else if (roll < 92)
                send(OP_RESTART, 6'($urandom_range(63)));
            else if (roll < 95)
            begin
                wait_drained();
                send(OP_SEARCH, text_sym());
            end
            else
                send(3'($urandom_range(7, 5)), 6'($urandom_range(63)));
        end
        quiet = 1'b0;
        send(OP_BUILD, 6'd0);
    endtask

    task automatic test_full_table();
        while (nodes_used < NODES)
        begin
            send(OP_INSERT, 6'($urandom_range(63)));
            if ($urandom_range(39) == 0)
                send(OP_END, 6'd0);
        end
        send(OP_INSERT, 6'($urandom_range(63)));
        send(OP_INSERT, 6'($urandom_range(63)));
        send(OP_END, 6'd0);
        send(OP_INSERT, 6'd62);
        send(OP_INSERT, 6'd61);
        send(OP_END, 6'd0);
        send(OP_BUILD, 6'd0);
        for (int i = 0; i < 40; i++)
            send(OP_SEARCH, 6'($urandom_range(63)));
        send(OP_RESTART, 6'd0);
    endtask

    task automatic test_empty_pattern();
        send(OP_END, 6'd0);
        for (int i = 0; i < 10; i++)
            send(OP_SEARCH, text_sym());
        send(OP_RESTART, 6'd0);
        send(OP_SEARCH, 6'd63);
    endtask

    initial
    begin
        in_if.valid = 1'b0;
        in_if.opcode = OP_INSERT;
        in_if.symbol = '0;
        out_if.ready = 1'b0;
        failed = 1'b0;
        quiet = 1'b0;
        stall_left = 0;
        sent = 0;
        clear_trie_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        test_full_table();
        test_empty_pattern();
        wait_drained();
        repeat (50) @(posedge clk);
        if (!failed && expected_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end
endmodule
